/* src/tmarm_pkg.sv */
// shared types and constants for the trimmed-mean regulation monitor
`default_nettype none
package tmarm_pkg;

	localparam int RING_DEPTH  = 10;
	localparam int SAMPLE_BITS = 12;
	localparam int NUM_CH      = 4;
	localparam int IN_BITS     = 12;
	localparam int FILT_W      = 16;
	localparam int CFG_W       = 16;
	localparam int CFG_ADDR_W  = 2;
	localparam int SUM_W       = SAMPLE_BITS + $clog2(RING_DEPTH);
	localparam int CMP_W       = (SUM_W > FILT_W) ? SUM_W : FILT_W;
	localparam int CNT_W       = $clog2(RING_DEPTH);
	localparam int IN_TDATA_W  = ((NUM_CH * IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS    = NUM_CH * FILT_W + 3;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [CFG_W-1:0] VOUT_LOW_RST  = 16'd7370;
	localparam logic [CFG_W-1:0] VOUT_HIGH_RST = 16'd7444;
	localparam logic [CFG_W-1:0] IOUT_LIM_RST  = 16'd12357;
	localparam logic [CFG_W-1:0] VIN_FAULT_RST = 16'd295;

	localparam logic [CFG_ADDR_W-1:0] REG_VOUT_LOW  = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_VOUT_HIGH = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_IOUT_LIM  = 2'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_VIN_FAULT = 2'd3;

	localparam int CH_VIN  = 0;
	localparam int CH_IIN  = 1;
	localparam int CH_VOUT = 2;
	localparam int CH_IOUT = 3;

	typedef logic [NUM_CH-1:0][SAMPLE_BITS-1:0] quad_t;

	typedef enum logic [1:0] {
		DRIVE_HOLD = 2'd0,
		DRIVE_UP   = 2'd1,
		DRIVE_DOWN = 2'd2
	} drive_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_TRIM,
		ST_DECIDE
	} state_t;

	typedef struct packed {
		logic first;
		logic step;
		logic trim;
	} acc_ctrl_t;

endpackage
`default_nettype wire

/* src/tmarm_cell.sv */
// one ring cell: holds one sample of each channel and passes it on
`default_nettype none
module tmarm_cell (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  shift_en,
	input  wire tmarm_pkg::quad_t d,
	output tmarm_pkg::quad_t     q
);
	import tmarm_pkg::*;

	quad_t quad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quad_q <= '0;
		end else if (shift_en) begin
			quad_q <= d;
		end
	end

	assign q = quad_q;

endmodule
`default_nettype wire

/* src/tmarm_acc.sv */
// per-channel sum, min and max over the walking chain, then trim and halve
`default_nettype none
module tmarm_acc (
	input  wire                                  clk,
	input  wire tmarm_pkg::acc_ctrl_t            ctrl,
	input  wire [tmarm_pkg::SAMPLE_BITS-1:0]     sample,
	output logic [tmarm_pkg::FILT_W-1:0]         filt
);
	import tmarm_pkg::*;

	logic [SUM_W-1:0]       sum_q;
	logic [SAMPLE_BITS-1:0] lo_q;
	logic [SAMPLE_BITS-1:0] hi_q;
	logic [FILT_W-1:0]      filt_q;
	logic [SUM_W-1:0]       diff;
	logic [CMP_W-1:0]       half;

	always_ff @(posedge clk) begin
		if (ctrl.first) begin
			sum_q <= SUM_W'(sample);
			lo_q  <= sample;
			hi_q  <= sample;
		end else if (ctrl.step) begin
			sum_q <= sum_q + SUM_W'(sample);
			if (sample < lo_q) begin
				lo_q <= sample;
			end
			if (sample > hi_q) begin
				hi_q <= sample;
			end
		end
	end

	always_comb begin
		diff = sum_q - SUM_W'(lo_q) - SUM_W'(hi_q);
		half = CMP_W'(diff >> 1);
	end

	always_ff @(posedge clk) begin
		if (ctrl.trim) begin
			if (half > CMP_W'({FILT_W{1'b1}})) begin
				filt_q <= {FILT_W{1'b1}};
			end else begin
				filt_q <= half[FILT_W-1:0];
			end
		end
	end

	assign filt = filt_q;

endmodule
`default_nettype wire

/* src/trimmed_mean_adc_regulation_monitor.sv */
// top level: cell chain, channel accumulators, sequencer and result register
// One transfer carries four 12-bit conversions (input voltage, input current, output
// voltage, output current). They shift into a row of ten cells that holds the last ten
// conversions of each channel (zeros after reset). The row then circulates once past four
// accumulators that collect sum, minimum and maximum; each filtered value is the sum less
// minimum and maximum, halved and saturated to 16 bits. The filtered values are compared
// with the four limit registers to give the drive action (up below the low limit, down
// above the high limit or above the current limit, else hold) and the low-input fault.
// After an input transfer the cell row circulates once past the accumulators, then a trim
// state and a decision state follow; the decision state loads the result register. The
// sequencer then returns to idle for the next input transfer, so no new input is taken
// before the previous item has left the decision state. Input is taken only while the
// sequencer is idle; a finished result waits in the output register while the next input
// is taken, and the decision cycle is held while an earlier result still waits there.
// Limit registers reset to 7370, 7444, 12357 and 295.
`default_nettype none
module trimmed_mean_adc_regulation_monitor (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   s_tvalid,
	output logic                                  s_tready,
	// in_voltage_sample, in_current_sample, out_voltage_sample, out_current_sample
	input  wire [tmarm_pkg::IN_TDATA_W-1:0]       s_tdata,
	output logic                                  m_tvalid,
	input  wire                                   m_tready,
	// filt_in_voltage, filt_in_current, filt_out_voltage, filt_out_current,
	// drive_action, low_input_fault, zero pad
	output logic [tmarm_pkg::OUT_TDATA_W-1:0]     m_tdata,
	input  wire                                   cfg_we,
	input  wire [tmarm_pkg::CFG_ADDR_W-1:0]       cfg_addr,
	input  wire [tmarm_pkg::CFG_W-1:0]            cfg_wdata
);
	import tmarm_pkg::*;

	state_t state_q, state_next;
	logic [CNT_W-1:0] cnt_q;

	logic [CFG_W-1:0] vout_low_q, vout_high_q, iout_lim_q, vin_fault_q;

	quad_t head;
	quad_t link [RING_DEPTH];
	quad_t new_quad;
	logic  accept, shift_en, walking, walk_last, out_free, out_load;
	acc_ctrl_t acc_ctrl;

	logic [FILT_W-1:0] filt [NUM_CH];
	drive_t            action;
	logic              fault;

	logic                   m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vout_low_q  <= VOUT_LOW_RST;
			vout_high_q <= VOUT_HIGH_RST;
			iout_lim_q  <= IOUT_LIM_RST;
			vin_fault_q <= VIN_FAULT_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_VOUT_LOW:  vout_low_q  <= cfg_wdata;
				REG_VOUT_HIGH: vout_high_q <= cfg_wdata;
				REG_IOUT_LIM:  iout_lim_q  <= cfg_wdata;
				REG_VIN_FAULT: vin_fault_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// sequencer
	assign walk_last = (cnt_q == CNT_W'(RING_DEPTH - 1));
	assign out_free  = !m_tvalid_q || m_tready;

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_next = ST_WALK;
			end
			ST_WALK: begin
				if (walk_last) state_next = ST_TRIM;
			end
			ST_TRIM: begin
				state_next = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (out_free) state_next = ST_IDLE;
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		walking  = 1'b0;
		acc_ctrl = '0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
			end
			ST_WALK: begin
				walking       = 1'b1;
				acc_ctrl.first = (cnt_q == '0);
				acc_ctrl.step  = (cnt_q != '0);
			end
			ST_TRIM: begin
				acc_ctrl.trim = 1'b1;
			end
			ST_DECIDE: begin
				out_load = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_next;
			if (walking) begin
				cnt_q <= walk_last ? '0 : cnt_q + 1'b1;
			end
		end
	end

	// cell row
	assign accept   = s_tvalid && s_tready;
	assign shift_en = accept || walking;

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			new_quad[c] = SAMPLE_BITS'(s_tdata[c*IN_BITS +: IN_BITS]);
		end
		head = accept ? new_quad : link[RING_DEPTH-1];
	end

	for (genvar i = 0; i < RING_DEPTH; i++) begin : g_cell
		tmarm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (shift_en),
			.d        ((i == 0) ? head : link[(i == 0) ? 0 : i - 1]),
			.q        (link[i])
		);
	end

	for (genvar c = 0; c < NUM_CH; c++) begin : g_acc
		tmarm_acc u_acc (
			.clk    (clk),
			.ctrl   (acc_ctrl),
			.sample (link[RING_DEPTH-1][c]),
			.filt   (filt[c])
		);
	end

	// decision
	always_comb begin
		if (filt[CH_VOUT] < vout_low_q) begin
			action = DRIVE_UP;
		end else if (filt[CH_VOUT] > vout_high_q) begin
			action = DRIVE_DOWN;
		end else if (filt[CH_IOUT] > iout_lim_q) begin
			action = DRIVE_DOWN;
		end else begin
			action = DRIVE_HOLD;
		end
		fault = (filt[CH_VIN] < vin_fault_q);
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= OUT_TDATA_W'({fault, action, filt[CH_IOUT], filt[CH_VOUT],
				filt[CH_IIN], filt[CH_VIN]});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
`default_nettype wire

/* src/tmarm_checker.sv */
// port-level checks for the regulation monitor, bound to the top level
`default_nettype none
module tmarm_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tvalid,
	input wire        s_tready,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [71:0] m_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped before transfer");

	a_action_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[65:64] != 2'd3))
		else $error("invalid drive action code");

	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while filter busy");

	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared without a filter pass");

endmodule

bind trimmed_mean_adc_regulation_monitor tmarm_checker u_tmarm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire
